[sv/irm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types, constants and the transaction program table for the
// register access master.
// ----------------------------------------------------------------------------
package irm_pkg;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd81;
    localparam logic [3:0] READ_LEN       = 4'd10;
    localparam logic [3:0] WRITE_LEN      = 4'd8;

    typedef enum logic [0:0] {
        REG_DEVICE_ADDRESS = 1'b0
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEG_START = 3'd0,
        SEG_DEVW  = 3'd1,
        SEG_DEVR  = 3'd2,
        SEG_REG   = 3'd3,
        SEG_VAL   = 3'd4,
        SEG_ACK   = 3'd5,
        SEG_READ  = 3'd6,
        SEG_STOP  = 3'd7
    } seg_t;

    typedef struct packed {
        logic       start_request;
        logic       req_type;
        logic [7:0] reg_address;
        logic [7:0] write_value;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack_seen;
    } result_t;

    // Segment executed at program position pos (1-based).
    function automatic seg_t seg_kind(input logic is_wr, input logic [3:0] pos);
        seg_t k;
        k = SEG_STOP;
        if (is_wr)
        begin
            unique case (pos)
                4'd1:    k = SEG_START;
                4'd2:    k = SEG_DEVW;
                4'd3:    k = SEG_ACK;
                4'd4:    k = SEG_REG;
                4'd5:    k = SEG_ACK;
                4'd6:    k = SEG_VAL;
                4'd7:    k = SEG_ACK;
                default: k = SEG_STOP;
            endcase
        end
        else
        begin
            unique case (pos)
                4'd1:    k = SEG_START;
                4'd2:    k = SEG_DEVW;
                4'd3:    k = SEG_ACK;
                4'd4:    k = SEG_REG;
                4'd5:    k = SEG_ACK;
                4'd6:    k = SEG_START;
                4'd7:    k = SEG_DEVR;
                4'd8:    k = SEG_ACK;
                4'd9:    k = SEG_READ;
                default: k = SEG_STOP;
            endcase
        end
        return k;
    endfunction

endpackage

[sv/irm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_queue
// Two-entry queue between the intake side and the bus sequencer.
// ----------------------------------------------------------------------------
module irm_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  irm_pkg::item_t push_item,
    input  logic           pop,
    output irm_pkg::item_t head_item,
    output logic           not_empty,
    output logic           full
);

    irm_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign head_item = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/irm_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_sequencer
// Bus sequencer: one pin event per tick taken from the queue, result held
// in an output register.
// ----------------------------------------------------------------------------
module irm_sequencer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [6:0]       device_address,
    input  logic             item_valid,
    input  irm_pkg::item_t   item,
    output logic             item_pop,
    output logic             res_valid,
    input  logic             res_stall,
    output irm_pkg::result_t res
);

    logic [3:0]       pos_reg;
    logic [3:0]       pos_next;
    logic [2:0]       mic_reg;
    logic [2:0]       mic_next;
    logic [2:0]       bit_count_reg;
    logic [2:0]       bit_count_next;
    logic [7:0]       tx_reg;
    logic [7:0]       tx_next;
    logic [7:0]       rx_reg;
    logic [7:0]       rx_next;
    logic             is_write_reg;
    logic             is_write_next;
    logic [7:0]       lreg_reg;
    logic [7:0]       lreg_next;
    logic [7:0]       lval_reg;
    logic [7:0]       lval_next;
    logic             ack_failed_reg;
    logic             ack_failed_next;
    logic [7:0]       read_byte_reg;
    logic [7:0]       read_byte_next;
    logic             scl_reg;
    logic             scl_next;
    logic             sda_reg;
    logic             sda_next;
    logic             done;
    logic             seg_end;
    logic [3:0]       len;
    logic [7:0]       src_byte;
    logic [7:0]       tx_cur;
    irm_pkg::seg_t    kind;
    logic             res_valid_reg;
    irm_pkg::result_t res_reg;

    assign item_pop  = item_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        mic_next        = mic_reg;
        bit_count_next  = bit_count_reg;
        tx_next         = tx_reg;
        rx_next         = rx_reg;
        is_write_next   = is_write_reg;
        lreg_next       = lreg_reg;
        lval_next       = lval_reg;
        ack_failed_next = ack_failed_reg;
        read_byte_next  = read_byte_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        done            = 1'b0;
        seg_end         = 1'b0;
        kind            = irm_pkg::SEG_STOP;
        src_byte        = 8'd0;
        tx_cur          = tx_reg;

        // request is honoured only while idle
        if (pos_reg == 4'd0 && item.start_request)
        begin
            is_write_next   = item.req_type;
            lreg_next       = item.reg_address;
            lval_next       = item.write_value;
            ack_failed_next = 1'b0;
            bit_count_next  = 3'd0;
            pos_next        = 4'd1;
            mic_next        = 3'd0;
        end

        len = is_write_next ? irm_pkg::WRITE_LEN : irm_pkg::READ_LEN;

        if (pos_next != 4'd0)
        begin
            if (pos_next > len)
            begin
                pos_next = 4'd0;
            end
            else
            begin
                kind = irm_pkg::seg_kind(is_write_next, pos_next);
                unique case (kind)
                    irm_pkg::SEG_DEVW: src_byte = {device_address, 1'b0};
                    irm_pkg::SEG_DEVR: src_byte = {device_address, 1'b1};
                    irm_pkg::SEG_REG:  src_byte = lreg_next;
                    default:           src_byte = lval_next;
                endcase

                unique case (kind)
                    irm_pkg::SEG_START:
                    begin
                        if (mic_next == 3'd0)      scl_next = 1'b0;
                        else if (mic_next == 3'd1) sda_next = 1'b1;
                        else if (mic_next == 3'd2) scl_next = 1'b1;
                        else if (mic_next == 3'd3) sda_next = 1'b0;
                        else
                        begin
                            scl_next = 1'b0;
                            seg_end  = 1'b1;
                        end
                    end
                    irm_pkg::SEG_DEVW, irm_pkg::SEG_DEVR,
                    irm_pkg::SEG_REG, irm_pkg::SEG_VAL:
                    begin
                        if (mic_next == 3'd0)
                        begin
                            tx_cur   = (bit_count_next == 3'd0) ? src_byte : tx_reg;
                            tx_next  = tx_cur;
                            sda_next = tx_cur[7];
                        end
                        else if (mic_next == 3'd1)
                        begin
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            scl_next       = 1'b0;
                            tx_next        = {tx_reg[6:0], 1'b0};
                            seg_end        = (bit_count_next == 3'd7);
                            bit_count_next = bit_count_next + 3'd1;
                            mic_next       = 3'd7;
                        end
                    end
                    irm_pkg::SEG_ACK:
                    begin
                        if (mic_next == 3'd0)
                        begin
                            sda_next = 1'b1;
                        end
                        else if (mic_next == 3'd1)
                        begin
                            scl_next        = 1'b1;
                            ack_failed_next = ack_failed_next | item.sda_in;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            seg_end  = 1'b1;
                        end
                    end
                    irm_pkg::SEG_READ:
                    begin
                        if (mic_next == 3'd0)
                        begin
                            scl_next = 1'b1;
                            rx_next  = {rx_reg[6:0], item.sda_in};
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            if (bit_count_next == 3'd7)
                            begin
                                read_byte_next = rx_reg;
                                seg_end        = 1'b1;
                            end
                            bit_count_next = bit_count_next + 3'd1;
                            mic_next       = 3'd7;
                        end
                    end
                    irm_pkg::SEG_STOP:
                    begin
                        if (mic_next == 3'd0)      sda_next = 1'b0;
                        else if (mic_next == 3'd1) scl_next = 1'b1;
                        else
                        begin
                            sda_next = 1'b1;
                            seg_end  = 1'b1;
                        end
                    end
                endcase

                if (seg_end)
                begin
                    bit_count_next = 3'd0;
                    mic_next       = 3'd0;
                    if (kind == irm_pkg::SEG_STOP)
                    begin
                        pos_next = 4'd0;
                        done     = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_next + 4'd1;
                    end
                end
                else
                begin
                    mic_next = mic_next + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 4'd0;
            mic_reg        <= 3'd0;
            bit_count_reg  <= 3'd0;
            tx_reg         <= 8'd0;
            rx_reg         <= 8'd0;
            is_write_reg   <= 1'b0;
            lreg_reg       <= 8'd0;
            lval_reg       <= 8'd0;
            ack_failed_reg <= 1'b0;
            read_byte_reg  <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                pos_reg        <= pos_next;
                mic_reg        <= mic_next;
                bit_count_reg  <= bit_count_next;
                tx_reg         <= tx_next;
                rx_reg         <= rx_next;
                is_write_reg   <= is_write_next;
                lreg_reg       <= lreg_next;
                lval_reg       <= lval_next;
                ack_failed_reg <= ack_failed_next;
                read_byte_reg  <= read_byte_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                res_valid_reg  <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_reg.scl_level   <= scl_next;
            res_reg.sda_release <= sda_next;
            res_reg.busy_res    <= (pos_next != 4'd0);
            res_reg.done_res    <= done;
            res_reg.read_data   <= read_byte_next;
            res_reg.nack_seen   <= ack_failed_next;
        end
    end

endmodule

[sv/i2c_register_access_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Tick-driven I2C master that performs single register reads and writes.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer (in_valid high, in_stall low) is one bus tick and
//   yields exactly one output transfer carrying the pin levels after that
//   tick plus busy, done, last read byte and the sticky nack flag.
//   A tick with start_request set while idle latches req_type, reg_address
//   and write_value and performs the first pin event on that same tick.
//   Input ticks enter a two-entry queue; the sequencer pops one per cycle
//   while the output is not stalled and registers its result, so one tick
//   per clock is sustained while out_stall is low. Each tick passes the
//   queue entry and then the result register before out_valid rises.
//   When out_stall is high the result register holds; the queue absorbs
//   up to two more ticks, after which in_stall rises.
//   The APB port holds device_address (reset 81) at byte address 0;
//   write it only while no tick is outstanding.
//   Reset empties the queue, drops out_valid and returns the bus to idle
//   with SCL and SDA released.
// ----------------------------------------------------------------------------
module i2c_register_access_master
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_request,
    input  logic        req_type,
    input  logic [7:0]  reg_address,
    input  logic [7:0]  write_value,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_release,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        nack_seen
);

    logic [6:0]       dev_addr_reg;
    logic             cfg_write;
    logic             in_accept;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    irm_pkg::item_t   in_item;
    irm_pkg::item_t   head_item;
    irm_pkg::result_t res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == irm_pkg::REG_DEVICE_ADDRESS) ?
                       {25'd0, dev_addr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= irm_pkg::DEV_ADDR_RESET;
        end
        else if (cfg_write && paddr[2] == irm_pkg::REG_DEVICE_ADDRESS)
        begin
            dev_addr_reg <= pwdata[6:0];
        end
    end

    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    assign in_item.start_request = start_request;
    assign in_item.req_type      = req_type;
    assign in_item.reg_address   = reg_address;
    assign in_item.write_value   = write_value;
    assign in_item.sda_in        = sda_in;

    irm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (in_item),
        .pop       (q_pop),
        .head_item (head_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    irm_sequencer u_seq
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .device_address (dev_addr_reg),
        .item_valid     (q_not_empty),
        .item           (head_item),
        .item_pop       (q_pop),
        .res_valid      (out_valid),
        .res_stall      (out_stall),
        .res            (res)
    );

    assign scl_level   = res.scl_level;
    assign sda_release = res.sda_release;
    assign busy_res    = res.busy_res;
    assign done_res    = res.done_res;
    assign read_data   = res.read_data;
    assign nack_seen   = res.nack_seen;

endmodule
